### hw/rtl/lea_pkg.sv
// Package: shared constants and control types for the LEA block cipher core.
`timescale 1ns / 1ps
`default_nettype none

package lea_pkg;

    localparam int MAX_ROUNDS_DEF  = 32;
    localparam int WORDS_PER_ROUND = 6;
    localparam int WORD_W          = 32;
    localparam int FUNC_W          = 2;
    localparam int INDEX_W         = 8;
    localparam int KEY_SIZE_W      = 2;
    localparam int BANK_W          = 3;

    // round count = BASE_ROUNDS + ROUND_STEP * key size code
    localparam int BASE_ROUNDS = 24;
    localparam int ROUND_STEP  = 4;

    // index / 6 == (index * DIV6_MUL) >> DIV6_SHIFT for any 8-bit index
    localparam int DIV6_MUL   = 171;
    localparam int DIV6_SHIFT = 10;

    localparam logic [FUNC_W-1:0] FUNC_LOAD    = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_ENCRYPT = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_DECRYPT = 2'd2;

    localparam logic [KEY_SIZE_W-1:0] KEY_SIZE_128 = 2'd0;
    localparam logic [KEY_SIZE_W-1:0] KEY_SIZE_192 = 2'd1;
    localparam logic [KEY_SIZE_W-1:0] KEY_SIZE_256 = 2'd2;

    typedef struct packed {
        logic key_wr;      // store one key word from the request payload
        logic load_block;  // capture the input block into the state
        logic rd_en;       // read one round key row
        logic round_en;    // apply one round to the state
        logic decrypt;     // round direction
        logic out_load;    // move the state into the result register
    } lea_cmd_t;

    typedef struct packed {
        logic out_free;    // result register can take a new block this cycle
    } lea_status_t;

endpackage

`default_nettype wire

### hw/rtl/lea_ifs.sv
// Interfaces: request and response channels of the LEA block cipher core.
`timescale 1ns / 1ps
`default_nettype none

interface lea_req_if;
    logic                                valid;
    logic                                ready;
    logic [lea_pkg::FUNC_W-1:0]          func;
    logic [lea_pkg::INDEX_W-1:0]         key_index;
    logic [lea_pkg::WORD_W-1:0]          key_word;
    logic [lea_pkg::WORD_W-1:0]          in_word0;
    logic [lea_pkg::WORD_W-1:0]          in_word1;
    logic [lea_pkg::WORD_W-1:0]          in_word2;
    logic [lea_pkg::WORD_W-1:0]          in_word3;

    modport source (
        output valid, func, key_index, key_word, in_word0, in_word1, in_word2, in_word3,
        input  ready
    );
    modport sink (
        input  valid, func, key_index, key_word, in_word0, in_word1, in_word2, in_word3,
        output ready
    );
endinterface

interface lea_rsp_if;
    logic                       valid;
    logic                       ready;
    logic [lea_pkg::WORD_W-1:0] out_word0;
    logic [lea_pkg::WORD_W-1:0] out_word1;
    logic [lea_pkg::WORD_W-1:0] out_word2;
    logic [lea_pkg::WORD_W-1:0] out_word3;

    modport source (
        output valid, out_word0, out_word1, out_word2, out_word3,
        input  ready
    );
    modport sink (
        input  valid, out_word0, out_word1, out_word2, out_word3,
        output ready
    );
endinterface

`default_nettype wire

### hw/rtl/lea_ctrl.sv
// Controller: key size register, round sequencing and key row addressing.
`timescale 1ns / 1ps
`default_nettype none

module lea_ctrl #(
    parameter int MAX_ROUNDS = lea_pkg::MAX_ROUNDS_DEF,
    parameter int RW         = $clog2(MAX_ROUNDS),
    parameter int CW         = $clog2(MAX_ROUNDS + 1)
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [lea_pkg::KEY_SIZE_W-1:0]    cfg_wdata,
    input  wire logic                              req_valid,
    output logic                                   req_ready,
    input  wire logic [lea_pkg::FUNC_W-1:0]        req_func,
    input  wire lea_pkg::lea_status_t              status,
    output lea_pkg::lea_cmd_t                      cmd,
    output logic [RW-1:0]                          rd_row
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_RUN    = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    logic [1:0]                       state_reg, state_next;
    logic [CW-1:0]                    left_reg, left_next;
    logic [RW-1:0]                    row_reg, row_next;
    logic                             dec_reg, dec_next;
    logic [lea_pkg::KEY_SIZE_W-1:0]   key_size_reg;
    logic [lea_pkg::KEY_SIZE_W-1:0]   ks_eff;
    logic [CW-1:0]                    rounds;
    int                               rounds_int;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_size_reg <= lea_pkg::KEY_SIZE_128;
        end
        else if (cfg_we)
        begin
            key_size_reg <= cfg_wdata;
        end
    end

    always_comb
    begin
        ks_eff = (key_size_reg > lea_pkg::KEY_SIZE_256) ? lea_pkg::KEY_SIZE_256 : key_size_reg;
        rounds_int = lea_pkg::BASE_ROUNDS + lea_pkg::ROUND_STEP * int'(ks_eff);
        if (rounds_int > MAX_ROUNDS)
        begin
            rounds_int = MAX_ROUNDS;
        end
        rounds = CW'(rounds_int);
    end

    always_comb
    begin
        state_next = state_reg;
        left_next  = left_reg;
        row_next   = row_reg;
        dec_next   = dec_reg;
        cmd        = '0;
        cmd.decrypt = dec_reg;
        req_ready  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    unique case (req_func)
                        lea_pkg::FUNC_LOAD:
                        begin
                            cmd.key_wr = 1'b1;
                        end
                        lea_pkg::FUNC_ENCRYPT, lea_pkg::FUNC_DECRYPT:
                        begin
                            cmd.load_block = 1'b1;
                            cmd.rd_en      = 1'b1;
                            dec_next       = (req_func == lea_pkg::FUNC_DECRYPT);
                            row_next       = dec_next ? RW'(rounds - CW'(1)) : '0;
                            left_next      = rounds;
                            state_next     = ST_RUN;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_RUN:
            begin
                cmd.round_en = 1'b1;
                left_next    = left_reg - CW'(1);
                if (left_reg != CW'(1))
                begin
                    cmd.rd_en = 1'b1;
                    row_next  = dec_reg ? row_reg - RW'(1) : row_reg + RW'(1);
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        rd_row = row_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            left_reg  <= '0;
            row_reg   <= '0;
            dec_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            left_reg  <= left_next;
            row_reg   <= row_next;
            dec_reg   <= dec_next;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/lea_datapath.sv
// Datapath: banked round key store, block state, ARX round and result register.
`timescale 1ns / 1ps
`default_nettype none

module lea_datapath #(
    parameter int MAX_ROUNDS = lea_pkg::MAX_ROUNDS_DEF,
    parameter int RW         = $clog2(MAX_ROUNDS)
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire lea_pkg::lea_cmd_t              cmd,
    output lea_pkg::lea_status_t                status,
    input  wire logic [RW-1:0]                  rd_row,
    input  wire logic [lea_pkg::INDEX_W-1:0]    key_index,
    input  wire logic [lea_pkg::WORD_W-1:0]     key_word,
    input  wire logic [lea_pkg::WORD_W-1:0]     in_word0,
    input  wire logic [lea_pkg::WORD_W-1:0]     in_word1,
    input  wire logic [lea_pkg::WORD_W-1:0]     in_word2,
    input  wire logic [lea_pkg::WORD_W-1:0]     in_word3,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [lea_pkg::WORD_W-1:0]          out_word0,
    output logic [lea_pkg::WORD_W-1:0]          out_word1,
    output logic [lea_pkg::WORD_W-1:0]          out_word2,
    output logic [lea_pkg::WORD_W-1:0]          out_word3
);

    localparam int W           = lea_pkg::WORD_W;
    localparam int NW          = lea_pkg::WORDS_PER_ROUND;
    localparam int STORE_DEPTH = MAX_ROUNDS * NW;
    localparam int IW          = lea_pkg::INDEX_W;
    localparam int PW          = 2 * IW;
    localparam int BW          = lea_pkg::BANK_W;

    function automatic logic [W-1:0] rotl(input logic [W-1:0] v, input int r);
        return (v << r) | (v >> (W - r));
    endfunction

    function automatic logic [W-1:0] rotr(input logic [W-1:0] v, input int r);
        return (v >> r) | (v << (W - r));
    endfunction

    logic [W-1:0]  x_reg [4];
    logic [W-1:0]  x_next [4];
    logic [W-1:0]  k_reg [NW];
    logic [W-1:0]  out_reg [4];
    logic          out_valid_reg, out_valid_next;

    logic [PW-1:0] div_prod;
    logic [IW-1:0] quot;
    logic [IW-1:0] remd;
    logic [RW-1:0] wr_row;
    logic [BW-1:0] wr_bank;
    logic          wr_en;

    // key_index -> (row, bank) = (index / 6, index % 6)
    always_comb
    begin
        div_prod = PW'(key_index) * PW'(lea_pkg::DIV6_MUL);
        quot     = IW'(div_prod >> lea_pkg::DIV6_SHIFT);
        remd     = key_index - IW'(quot * IW'(NW));
        wr_row   = RW'(quot);
        wr_bank  = BW'(remd);
        wr_en    = cmd.key_wr && (key_index < IW'(STORE_DEPTH));
    end

    for (genvar j = 0; j < NW; j++)
    begin : g_bank
        logic [W-1:0] mem [MAX_ROUNDS];

        always_ff @(posedge clk)
        begin
            if (wr_en && (wr_bank == BW'(j)))
            begin
                mem[wr_row] <= key_word;
            end
            if (cmd.rd_en)
            begin
                k_reg[j] <= mem[rd_row];
            end
        end
    end

    always_comb
    begin
        if (cmd.decrypt)
        begin
            x_next[0] = x_reg[3];
            x_next[1] = (rotr(x_reg[0], 9) - (x_next[0] ^ k_reg[0])) ^ k_reg[1];
            x_next[2] = (rotl(x_reg[1], 5) - (x_next[1] ^ k_reg[2])) ^ k_reg[3];
            x_next[3] = (rotl(x_reg[2], 3) - (x_next[2] ^ k_reg[4])) ^ k_reg[5];
        end
        else
        begin
            x_next[0] = rotl((x_reg[0] ^ k_reg[0]) + (x_reg[1] ^ k_reg[1]), 9);
            x_next[1] = rotr((x_reg[1] ^ k_reg[2]) + (x_reg[2] ^ k_reg[3]), 5);
            x_next[2] = rotr((x_reg[2] ^ k_reg[4]) + (x_reg[3] ^ k_reg[5]), 3);
            x_next[3] = x_reg[0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_block)
        begin
            x_reg[0] <= in_word0;
            x_reg[1] <= in_word1;
            x_reg[2] <= in_word2;
            x_reg[3] <= in_word3;
        end
        else if (cmd.round_en)
        begin
            x_reg <= x_next;
        end
        if (cmd.out_load)
        begin
            out_reg <= x_reg;
        end
    end

    always_comb
    begin
        status.out_free = !out_valid_reg || out_ready;
        out_valid_next  = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word0 = out_reg[0];
    assign out_word1 = out_reg[1];
    assign out_word2 = out_reg[2];
    assign out_word3 = out_reg[3];

endmodule

`default_nettype wire

### hw/rtl/lea_block_cipher.sv
// Top level: LEA 128-bit block cipher core, controller plus datapath.
//
//  channel  modport  payload                                         transfer
//  req      sink     func, key_index, key_word, in_word0..in_word3   valid && ready
//  rsp      source   out_word0..out_word3                            valid && ready
//  cfg      write    cfg_wdata = key_size                            cfg_we
//
// Load: 1 cycle, next item taken the cycle after.
// Encrypt/decrypt: 24/28/32 rounds, one round per cycle,
// set by the single-round ARX loop fed from six key banks read one row a cycle.
// Request ready only while idle; a waiting result does not block new requests.
// Result register holds until rsp.ready; a finished block waits for it.
// Reset clears control state and key_size; key store is undefined until loaded.
`timescale 1ns / 1ps
`default_nettype none

module lea_block_cipher #(
    parameter int MAX_ROUNDS = lea_pkg::MAX_ROUNDS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [lea_pkg::KEY_SIZE_W-1:0] cfg_wdata,
    lea_req_if.sink                             req,
    lea_rsp_if.source                           rsp
);

    localparam int RW = $clog2(MAX_ROUNDS);
    localparam int CW = $clog2(MAX_ROUNDS + 1);

    lea_pkg::lea_cmd_t    cmd;
    lea_pkg::lea_status_t status;
    logic [RW-1:0]        rd_row;

    lea_ctrl #(
        .MAX_ROUNDS (MAX_ROUNDS),
        .RW         (RW),
        .CW         (CW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .req_func  (req.func),
        .status    (status),
        .cmd       (cmd),
        .rd_row    (rd_row)
    );

    lea_datapath #(
        .MAX_ROUNDS (MAX_ROUNDS),
        .RW         (RW)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .rd_row    (rd_row),
        .key_index (req.key_index),
        .key_word  (req.key_word),
        .in_word0  (req.in_word0),
        .in_word1  (req.in_word1),
        .in_word2  (req.in_word2),
        .in_word3  (req.in_word3),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .out_word0 (rsp.out_word0),
        .out_word1 (rsp.out_word1),
        .out_word2 (rsp.out_word2),
        .out_word3 (rsp.out_word3)
    );

endmodule

`default_nettype wire

### hw/rtl/lea_checker.sv
// Checker: port-level assertions for the LEA block cipher core, with its bind.
`timescale 1ns / 1ps
`default_nettype none

module lea_checker (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        req_valid,
    input wire logic                        req_ready,
    input wire logic [lea_pkg::FUNC_W-1:0]  req_func,
    input wire logic                        rsp_valid,
    input wire logic                        rsp_ready,
    input wire logic [lea_pkg::WORD_W-1:0]  rsp_word0,
    input wire logic [lea_pkg::WORD_W-1:0]  rsp_word1,
    input wire logic [lea_pkg::WORD_W-1:0]  rsp_word2,
    input wire logic [lea_pkg::WORD_W-1:0]  rsp_word3
);

    logic req_xfer;
    logic req_block;

    assign req_xfer  = req_valid && req_ready;
    assign req_block = (req_func == lea_pkg::FUNC_ENCRYPT) ||
                       (req_func == lea_pkg::FUNC_DECRYPT);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("rsp valid dropped before transfer");

    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable({rsp_word0, rsp_word1, rsp_word2, rsp_word3}))
        else $error("rsp payload changed while stalled");

    a_busy_after_block: assert property (@(posedge clk) disable iff (!rst_n)
        req_xfer && req_block |=> !req_ready)
        else $error("request taken while a block is in progress");

    a_idle_after_other: assert property (@(posedge clk) disable iff (!rst_n)
        req_xfer && !req_block |=> req_ready)
        else $error("load or unused code left the core busy");

    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        req_xfer && req_block && !rsp_valid |=> !rsp_valid)
        else $error("result appeared too soon after block transfer");

endmodule

bind lea_block_cipher lea_checker u_lea_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .req_func  (req.func),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_word0 (rsp.out_word0),
    .rsp_word1 (rsp.out_word1),
    .rsp_word2 (rsp.out_word2),
    .rsp_word3 (rsp.out_word3)
);

`default_nettype wire

### tb/tb_lea_block_cipher.sv
// Testbench: self-checking random and directed test of the LEA block cipher core.
`timescale 1ns / 1ps

module tb_lea_block_cipher;
    import lea_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
    localparam int STORE_DEPTH   = MAX_ROUNDS_DEF * WORDS_PER_ROUND;
    localparam int SETTLE_CYCLES = 40;
    localparam int STALL_CYCLES  = 300;
    localparam int PHASE_ITEMS   = 288;
    localparam int CYCLE_LIMIT   = 800000;

    typedef logic [3:0][WORD_W-1:0] block_t;

    typedef struct {
        logic [FUNC_W-1:0]  func;
        logic [INDEX_W-1:0] key_index;
        logic [WORD_W-1:0]  key_word;
        block_t             blk;
    } cipher_req_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [KEY_SIZE_W-1:0] cfg_wdata;

    lea_req_if req_bus ();
    lea_rsp_if rsp_bus ();

    lea_block_cipher u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req_bus),
        .rsp       (rsp_bus)
    );

    cipher_req_t       cipher_requests[$];
    block_t            cipher_results_due[$];
    logic [WORD_W-1:0] key_table [STORE_DEPTH];
    logic [KEY_SIZE_W-1:0] model_key_size;
    logic              req_taken;
    logic              idle_on;
    logic              stall_go;
    logic              rsp_hold;
    int                req_gap;
    int                rsp_gap;
    int                error_count;
    int                result_count;
    int                cycle_count;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic logic [WORD_W-1:0] rotate_left(input logic [WORD_W-1:0] v,
                                                      input int unsigned s);
        return (v << s) | (v >> (WORD_W - s));
    endfunction

    // expected output block for one encrypt or decrypt transfer
    function automatic block_t lea_transform(input logic [FUNC_W-1:0] func, input block_t x);
        int unsigned ks;
        int unsigned rounds;
        int unsigned b;
        block_t n;
        ks = (model_key_size > KEY_SIZE_256) ? KEY_SIZE_256 : model_key_size;
        rounds = BASE_ROUNDS + ROUND_STEP * ks;
        if (rounds > MAX_ROUNDS_DEF)
            rounds = MAX_ROUNDS_DEF;
        if (func == FUNC_ENCRYPT)
        begin
            for (int r = 0; r < rounds; r++)
            begin
                b = r * WORDS_PER_ROUND;
                n[0] = rotate_left((x[0] ^ key_table[b]) + (x[1] ^ key_table[b+1]), 9);
                n[1] = rotate_left((x[1] ^ key_table[b+2]) + (x[2] ^ key_table[b+3]), 27);
                n[2] = rotate_left((x[2] ^ key_table[b+4]) + (x[3] ^ key_table[b+5]), 29);
                n[3] = x[0];
                x = n;
            end
        end
        else
        begin
            for (int r = rounds - 1; r >= 0; r--)
            begin
                b = r * WORDS_PER_ROUND;
                n[0] = x[3];
                n[1] = (rotate_left(x[0], 23) - (n[0] ^ key_table[b])) ^ key_table[b+1];
                n[2] = (rotate_left(x[1], 5) - (n[1] ^ key_table[b+2])) ^ key_table[b+3];
                n[3] = (rotate_left(x[2], 3) - (n[2] ^ key_table[b+4])) ^ key_table[b+5];
                x = n;
            end
        end
        return x;
    endfunction

    task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                   input logic [WORD_W-1:0] want);
        if (error_count < 40)
            $display("MISMATCH result %0d %s: got %h want %h", result_count, what, got, want);
        error_count++;
    endtask

    task automatic queue_request(input logic [FUNC_W-1:0] func, input logic [INDEX_W-1:0] idx,
                                 input logic [WORD_W-1:0] word, input logic [WORD_W-1:0] w0,
                                 input logic [WORD_W-1:0] w1, input logic [WORD_W-1:0] w2,
                                 input logic [WORD_W-1:0] w3);
        cipher_req_t r;
        r.func = func;
        r.key_index = idx;
        r.key_word = word;
        r.blk = {w3, w2, w1, w0};
        cipher_requests.push_back(r);
    endtask

    function automatic cipher_req_t random_request();
        cipher_req_t r;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            r.func = FUNC_ENCRYPT;
        else if (pick < 80)
            r.func = FUNC_DECRYPT;
        else if (pick < 95)
            r.func = FUNC_LOAD;
        else
            r.func = FUNC_UNUSED;
        if ($urandom_range(0, 3) == 0)
            r.key_index = INDEX_W'($urandom_range(STORE_DEPTH, 255));
        else
            r.key_index = INDEX_W'($urandom_range(0, STORE_DEPTH - 1));
        r.key_word = $urandom();
        for (int i = 0; i < 4; i++)
            r.blk[i] = $urandom();
        return r;
    endfunction

    task automatic write_key_size(input logic [KEY_SIZE_W-1:0] ks);
        @(negedge clk);
        cfg_wdata <= ks;
        cfg_we <= 1'b1;
        model_key_size = ks;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain_and_settle();
        while (cipher_requests.size() != 0 || cipher_results_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // request driver
    always @(negedge clk)
    begin
        if (!rst_n)
            req_bus.valid <= 1'b0;
        else if (!req_bus.valid || req_taken)
        begin
            if (req_gap == 0 && idle_on && $urandom_range(0, 7) == 0)
                req_gap = $urandom_range(1, 14);
            if (req_gap > 0)
            begin
                req_gap--;
                req_bus.valid <= 1'b0;
            end
            else if (cipher_requests.size() != 0)
            begin
                req_bus.valid     <= 1'b1;
                req_bus.func      <= cipher_requests[0].func;
                req_bus.key_index <= cipher_requests[0].key_index;
                req_bus.key_word  <= cipher_requests[0].key_word;
                req_bus.in_word0  <= cipher_requests[0].blk[0];
                req_bus.in_word1  <= cipher_requests[0].blk[1];
                req_bus.in_word2  <= cipher_requests[0].blk[2];
                req_bus.in_word3  <= cipher_requests[0].blk[3];
            end
            else
                req_bus.valid <= 1'b0;
        end
    end

    // response ready driver
    always @(negedge clk)
    begin
        if (rsp_gap == 0 && idle_on && $urandom_range(0, 5) == 0)
            rsp_gap = $urandom_range(1, 14);
        if (rsp_hold)
            rsp_bus.ready <= 1'b0;
        else if (rsp_gap > 0)
        begin
            rsp_gap--;
            rsp_bus.ready <= 1'b0;
        end
        else
            rsp_bus.ready <= 1'b1;
    end

    // long receiver stall so the core backs up into its request side
    initial
    begin
        rsp_hold = 1'b0;
        wait (stall_go);
        @(posedge clk);
        rsp_hold = 1'b1;
        repeat (STALL_CYCLES) @(posedge clk);
        rsp_hold = 1'b0;
    end

    // request transfer: update key table, predict the output block
    always @(posedge clk)
    begin
        req_taken <= rst_n && req_bus.valid && req_bus.ready;
        if (rst_n && req_bus.valid && req_bus.ready)
        begin
            cipher_req_t cur;
            cur = cipher_requests.pop_front();
            if (cur.func == FUNC_LOAD)
            begin
                if (cur.key_index < STORE_DEPTH)
                    key_table[cur.key_index] = cur.key_word;
            end
            else if (cur.func != FUNC_UNUSED)
                cipher_results_due.push_back(lea_transform(cur.func, cur.blk));
        end
    end

    // response transfer check
    always @(posedge clk)
    begin
        if (rst_n && rsp_bus.valid && rsp_bus.ready)
        begin
            block_t got;
            block_t want;
            got = {rsp_bus.out_word3, rsp_bus.out_word2, rsp_bus.out_word1, rsp_bus.out_word0};
            if (cipher_results_due.size() == 0)
                report_mismatch("unexpected result, word0", got[0], 'x);
            else
            begin
                want = cipher_results_due.pop_front();
                if (got[0] !== want[0])
                    report_mismatch("out_word0", got[0], want[0]);
                if (got[1] !== want[1])
                    report_mismatch("out_word1", got[1], want[1]);
                if (got[2] !== want[2])
                    report_mismatch("out_word2", got[2], want[2]);
                if (got[3] !== want[3])
                    report_mismatch("out_word3", got[3], want[3]);
            end
            result_count++;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb_lea_block_cipher: errors");
            $finish;
        end
    end

    initial
    begin : stimulus
        logic [KEY_SIZE_W-1:0] ks_plan [5];
        ks_plan = '{KEY_SIZE_128, KEY_SIZE_192, 2'd3, KEY_SIZE_256, KEY_SIZE_128};
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        req_bus.valid = 1'b0;
        req_bus.func = FUNC_LOAD;
        req_bus.key_index = '0;
        req_bus.key_word = '0;
        req_bus.in_word0 = '0;
        req_bus.in_word1 = '0;
        req_bus.in_word2 = '0;
        req_bus.in_word3 = '0;
        rsp_bus.ready = 1'b0;
        req_taken = 1'b0;
        idle_on = 1'b1;
        stall_go = 1'b0;
        req_gap = 0;
        rsp_gap = 0;
        error_count = 0;
        result_count = 0;
        cycle_count = 0;
        model_key_size = KEY_SIZE_128;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int p = 0; p < 5; p++)
        begin
            if (p == 4)
                idle_on = 1'b0;
            write_key_size(ks_plan[p]);
            @(posedge clk);
            if (p == 0)
            begin
                // fill the whole round key store before any block is run
                for (int i = 0; i < STORE_DEPTH; i++)
                    queue_request(FUNC_LOAD, INDEX_W'(i), $urandom(), 0, 0, 0, 0);
                queue_request(FUNC_ENCRYPT, 0, 0, 0, 0, 0, 0);
                queue_request(FUNC_ENCRYPT, '1, '1, '1, '1, '1, '1);
                queue_request(FUNC_DECRYPT, 0, 0, 0, 0, 0, 0);
                queue_request(FUNC_DECRYPT, '1, '1, '1, '1, '1, '1);
                queue_request(FUNC_LOAD, 8'd192, '1, '1, '1, '1, '1);
                queue_request(FUNC_LOAD, 8'd255, 0, 0, 0, 0, 0);
                queue_request(FUNC_UNUSED, '1, '1, '1, '1, '1, '1);
                queue_request(FUNC_UNUSED, 0, 0, 0, 0, 0, 0);
                queue_request(FUNC_LOAD, 8'd0, 0, '1, '1, '1, '1);
                queue_request(FUNC_LOAD, 8'd191, '1, 0, 0, 0, 0);
                queue_request(FUNC_ENCRYPT, 0, 0, $urandom(), $urandom(), $urandom(), $urandom());
                queue_request(FUNC_DECRYPT, 0, 0, $urandom(), $urandom(), $urandom(), $urandom());
                queue_request(FUNC_LOAD, 8'd0, '1, 0, 0, 0, 0);
                queue_request(FUNC_LOAD, 8'd191, 0, 0, 0, 0, 0);
                queue_request(FUNC_ENCRYPT, 0, 0, '1, '1, '1, '1);
                queue_request(FUNC_DECRYPT, 0, 0, 0, 0, 0, 0);
                queue_request(FUNC_ENCRYPT, 0, 0, 32'h8000_0000, 32'h0000_0001,
                              32'h7fff_ffff, 32'hffff_fffe);
                queue_request(FUNC_DECRYPT, 0, 0, 32'h8000_0000, 32'h0000_0001,
                              32'h7fff_ffff, 32'hffff_fffe);
            end
            for (int i = 0; i < PHASE_ITEMS; i++)
                cipher_requests.push_back(random_request());
            if (p == 1)
                stall_go = 1'b1;
            drain_and_settle();
        end

        if (error_count == 0)
            $display("tb_lea_block_cipher: clean");
        else
            $display("tb_lea_block_cipher: errors");
        $finish;
    end

endmodule

### files.f
hw/rtl/lea_pkg.sv
hw/rtl/lea_ifs.sv
hw/rtl/lea_ctrl.sv
hw/rtl/lea_datapath.sv
hw/rtl/lea_block_cipher.sv
hw/rtl/lea_checker.sv
tb/tb_lea_block_cipher.sv
